>>> hdl/multi_tap_remote_key_translator_unit_defines.svh
// Assertion macros used by the checker file of the key translator.
`ifndef MULTI_TAP_REMOTE_KEY_TRANSLATOR_UNIT_DEFINES_SVH
`define MULTI_TAP_REMOTE_KEY_TRANSLATOR_UNIT_DEFINES_SVH

// Check a property on every clock edge outside reset.
`define MTKT_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define MTKT_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> hdl/mtkt_pkg.sv
// Types, codes and the multi-tap symbol table of the key translator.
package mtkt_pkg;

  localparam int TICK_BITS = 20;
  localparam int TIMEOUT_W = 20;
  localparam int STEP_W    = 7;
  localparam int CFG_W     = 20;
  localparam int CFG_IDX_W = 2;

  localparam logic [TICK_BITS-1:0] TICK_MAX = '1;

  // Command field codes
  localparam logic CMD_TICK   = 1'b0;
  localparam logic CMD_BUTTON = 1'b1;

  // Button codes
  localparam logic [4:0] BTN_LAST_DIGIT = 5'd9;
  localparam logic [4:0] BTN_ENTER      = 5'd10;
  localparam logic [4:0] BTN_MODE       = 5'd11;
  localparam logic [4:0] BTN_UP         = 5'd12;
  localparam logic [4:0] BTN_DOWN       = 5'd13;
  localparam logic [4:0] BTN_RIGHT      = 5'd14;
  localparam logic [4:0] BTN_LEFT       = 5'd15;
  localparam logic [4:0] BTN_CLICK      = 5'd16;

  localparam logic [3:0] NO_DIGIT = 4'd15;

  // Action codes
  localparam logic [1:0] ACT_KEY   = 2'd0;
  localparam logic [1:0] ACT_MOVE  = 2'd1;
  localparam logic [1:0] ACT_CLICK = 2'd2;

  // Key codes
  localparam logic [7:0] KC_BACKSPACE = 8'd14;
  localparam logic [7:0] KC_ENTER     = 8'd28;
  localparam logic [7:0] KC_UP        = 8'd103;
  localparam logic [7:0] KC_DOWN      = 8'd108;
  localparam logic [7:0] KC_RIGHT     = 8'd106;
  localparam logic [7:0] KC_LEFT      = 8'd105;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_X  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STEP_Y  = 2'd2;

  // Reset values of the configuration registers
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 20'd1000;
  localparam logic [STEP_W-1:0]    STEP_RST    = 7'd20;

  typedef struct packed {
    logic [1:0]        action;
    logic [7:0]        key_code;
    logic signed [7:0] move_dx;
    logic signed [7:0] move_dy;
    logic              last;
  } res_t;

  // Results caused by one input item, in emit order
  typedef struct packed {
    logic [1:0] cnt;
    res_t       r0;
    res_t       r1;
  } res_pair_t;

  // Symbol for a digit: slot 0 is the digit's own code, slots 1-3 the taps after it
  function automatic logic [7:0] tap_code(input logic [3:0] digit, input logic [1:0] slot);
    logic [31:0] row;
    begin
      case (digit)
        4'd0:    row = {8'd11, 8'd57, 8'd14, 8'd0};
        4'd1:    row = {8'd2,  8'd30, 8'd48, 8'd46};
        4'd2:    row = {8'd3,  8'd32, 8'd18, 8'd33};
        4'd3:    row = {8'd4,  8'd34, 8'd35, 8'd23};
        4'd4:    row = {8'd5,  8'd36, 8'd37, 8'd38};
        4'd5:    row = {8'd6,  8'd50, 8'd49, 8'd24};
        4'd6:    row = {8'd7,  8'd25, 8'd16, 8'd19};
        4'd7:    row = {8'd8,  8'd31, 8'd20, 8'd22};
        4'd8:    row = {8'd9,  8'd47, 8'd17, 8'd45};
        4'd9:    row = {8'd10, 8'd21, 8'd44, 8'd10};
        default: row = '0;
      endcase
      case (slot)
        2'd0:    tap_code = row[31:24];
        2'd1:    tap_code = row[23:16];
        2'd2:    tap_code = row[15:8];
        default: tap_code = row[7:0];
      endcase
    end
  endfunction

endpackage

>>> hdl/mtkt_core.sv
// Translator state, configuration registers and the per-item decode.
module mtkt_core import mtkt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 accept,
  input  logic                 cmd,
  input  logic [4:0]           button,
  output res_pair_t            pair
);

  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [STEP_W-1:0]    mouse_step_x;
  logic [STEP_W-1:0]    mouse_step_y;

  logic [3:0]           prev_digit, prev_digit_next;
  logic [2:0]           tap_count, tap_count_next;
  logic [TICK_BITS-1:0] idle_ticks, idle_ticks_next;
  logic                 mouse_mode, mouse_mode_next;

  logic       restart;
  logic [7:0] sym;
  logic [7:0] step_x8, step_y8;

  assign step_x8 = {1'b0, mouse_step_x};
  assign step_y8 = {1'b0, mouse_step_y};

  // Hold configuration, write on enable
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RST;
      mouse_step_x  <= STEP_RST;
      mouse_step_y  <= STEP_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TIMEOUT: timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        REG_STEP_X:  mouse_step_x  <= cfg_data[STEP_W-1:0];
        REG_STEP_Y:  mouse_step_y  <= cfg_data[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  assign restart = (button[3:0] != prev_digit) || (prev_digit == NO_DIGIT) ||
                   (idle_ticks >= timeout_ticks);

  // Decode the accepted beat against current state
  always_comb begin
    prev_digit_next = prev_digit;
    tap_count_next  = tap_count;
    idle_ticks_next = idle_ticks;
    mouse_mode_next = mouse_mode;
    pair            = '0;
    sym             = '0;
    if (accept) begin
      if (cmd == CMD_TICK) begin
        if (idle_ticks != TICK_MAX) idle_ticks_next = idle_ticks + 1'b1;
      end else if (button <= BTN_LAST_DIGIT) begin
        if (restart) begin
          tap_count_next = 3'd1;
        end else if (tap_count < 3'd4) begin
          tap_count_next = tap_count + 3'd1;
        end
        prev_digit_next = button[3:0];
        idle_ticks_next = '0;
        if (tap_count_next == 3'd1) begin
          pair.cnt         = 2'd1;
          pair.r0.key_code = tap_code(button[3:0], 2'd0);
          pair.r0.last     = 1'b1;
        end else begin
          sym              = tap_code(button[3:0], 2'(tap_count_next - 3'd1));
          pair.r0.key_code = KC_BACKSPACE;
          if (sym != 8'd0) begin
            pair.cnt         = 2'd2;
            pair.r1.key_code = sym;
            pair.r1.last     = 1'b1;
          end else begin
            pair.cnt     = 2'd1;
            pair.r0.last = 1'b1;
          end
        end
      end else if (button == BTN_ENTER) begin
        pair.cnt         = 2'd1;
        pair.r0.key_code = KC_ENTER;
        pair.r0.last     = 1'b1;
      end else if (button == BTN_MODE) begin
        mouse_mode_next = ~mouse_mode;
      end else if (button <= BTN_LEFT) begin
        pair.cnt     = 2'd1;
        pair.r0.last = 1'b1;
        if (mouse_mode) begin
          pair.r0.action = ACT_MOVE;
          case (button)
            BTN_UP:    pair.r0.move_dy = 8'd0 - step_y8;
            BTN_DOWN:  pair.r0.move_dy = step_y8;
            BTN_RIGHT: pair.r0.move_dx = step_x8;
            default:   pair.r0.move_dx = 8'd0 - step_x8;
          endcase
        end else begin
          case (button)
            BTN_UP:    pair.r0.key_code = KC_UP;
            BTN_DOWN:  pair.r0.key_code = KC_DOWN;
            BTN_RIGHT: pair.r0.key_code = KC_RIGHT;
            default:   pair.r0.key_code = KC_LEFT;
          endcase
        end
      end else if (button == BTN_CLICK) begin
        if (mouse_mode) begin
          pair.cnt       = 2'd1;
          pair.r0.action = ACT_CLICK;
          pair.r0.last   = 1'b1;
        end
      end
    end
  end

  // Advance translator state
  always_ff @(posedge clk) begin
    if (rst) begin
      prev_digit <= NO_DIGIT;
      tap_count  <= '0;
      idle_ticks <= '0;
      mouse_mode <= 1'b0;
    end else begin
      prev_digit <= prev_digit_next;
      tap_count  <= tap_count_next;
      idle_ticks <= idle_ticks_next;
      mouse_mode <= mouse_mode_next;
    end
  end

endmodule

>>> hdl/mtkt_result_fifo.sv
// Four-entry result queue: takes up to two results a cycle, sends one.
module mtkt_result_fifo import mtkt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  res_pair_t pair,
  input  logic      pop,
  output logic      space,
  output logic      head_valid,
  output res_t      head
);

  res_t       mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count, count_next;
  logic       do_pop;

  assign do_pop     = pop && (count != 3'd0);
  assign space      = count <= 3'd2;
  assign head_valid = count != 3'd0;
  assign head       = mem[rd_ptr];
  assign count_next = count + {1'b0, pair.cnt} - {2'b0, do_pop};

  // Write the new results in order
  always_ff @(posedge clk) begin
    if (pair.cnt != 2'd0) mem[wr_ptr] <= pair.r0;
    if (pair.cnt == 2'd2) mem[wr_ptr + 2'd1] <= pair.r1;
  end

  // Advance pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + pair.cnt;
      rd_ptr <= rd_ptr + {1'b0, do_pop};
      count  <= count_next;
    end
  end

endmodule

>>> hdl/multi_tap_remote_key_translator_unit.sv
// Results of an accepted input beat are decoded combinationally and registered in the result queue.
// Throughput: one input beat per cycle while the queue has room; its single read port
// sends one result per cycle while out_ready is high, so backspace plus symbol is two beats.
// Input is taken while the four-entry result queue has room for two results.
// Reset: config returns to defaults, state to no digit and arrow mode, queue empty.
module multi_tap_remote_key_translator_unit import mtkt_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic                 cmd,
  input  logic [4:0]           button,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           action,
  output logic [7:0]           key_code,
  output logic signed [7:0]    move_dx,
  output logic signed [7:0]    move_dy,
  output logic                 last
);

  res_pair_t pair;
  res_t      head;
  logic      space;

  assign in_ready = space;

  mtkt_core u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .accept    (in_valid && space),
    .cmd       (cmd),
    .button    (button),
    .pair      (pair)
  );

  mtkt_result_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .pair       (pair),
    .pop        (out_ready),
    .space      (space),
    .head_valid (out_valid),
    .head       (head)
  );

  assign action   = head.action;
  assign key_code = head.key_code;
  assign move_dx  = head.move_dx;
  assign move_dy  = head.move_dy;
  assign last     = head.last;

endmodule

>>> hdl/mtkt_checker.sv
// Port-level checker for the key translator and its bind.
`include "multi_tap_remote_key_translator_unit_defines.svh"

module mtkt_checker import mtkt_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_ready,
  input logic              cmd,
  input logic              out_valid,
  input logic              out_ready,
  input logic [1:0]        action,
  input logic [7:0]        key_code,
  input logic signed [7:0] move_dx,
  input logic signed [7:0] move_dy,
  input logic              last
);

  `MTKT_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result offered right after reset")
  `MTKT_ASSERT(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(key_code), "stalled result beat changed")
  `MTKT_ASSERT(a_click_clean, out_valid && action == ACT_CLICK |-> last && key_code == 8'd0 && move_dx == 8'sd0 && move_dy == 8'sd0, "click beat with stray fields")
  `MTKT_ASSERT(a_move_clean, out_valid && action == ACT_MOVE |-> last && key_code == 8'd0, "move beat with key code or not last")
  `MTKT_ASSERT(a_tick_silent, in_valid && in_ready && cmd == CMD_TICK && !out_valid |=> !out_valid, "tick produced a result")

endmodule

bind multi_tap_remote_key_translator_unit mtkt_checker u_mtkt_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .cmd       (cmd),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .action    (action),
  .key_code  (key_code),
  .move_dx   (move_dx),
  .move_dy   (move_dy),
  .last      (last)
);

>>> test/tb.sv
// Testbench for the multi-tap key translator: predicted action stream checked beat by beat.
`timescale 1ns / 100ps

module tb;
  import mtkt_pkg::*;

  // Unknown buttons start here
  localparam logic [4:0] BTN_OTHER = 5'd17;
  localparam int HOLD_CYCLES = 300;
  localparam int MAX_PRINTED = 100;

  // Own code, then symbols for taps 2, 3 and 4+ (0 means nothing after the backspace)
  localparam logic [0:9][0:3][7:0] TAP_SYMBOLS = {
    8'd11, 8'd57, 8'd14, 8'd0,
    8'd2,  8'd30, 8'd48, 8'd46,
    8'd3,  8'd32, 8'd18, 8'd33,
    8'd4,  8'd34, 8'd35, 8'd23,
    8'd5,  8'd36, 8'd37, 8'd38,
    8'd6,  8'd50, 8'd49, 8'd24,
    8'd7,  8'd25, 8'd16, 8'd19,
    8'd8,  8'd31, 8'd20, 8'd22,
    8'd9,  8'd47, 8'd17, 8'd45,
    8'd10, 8'd21, 8'd44, 8'd10
  };

  typedef struct packed {
    logic       cmd;
    logic [4:0] button;
  } remote_evt_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]     cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic                 cmd = 1'b0;
  logic [4:0]           button = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [1:0]           action;
  logic [7:0]           key_code;
  logic signed [7:0]    move_dx;
  logic signed [7:0]    move_dy;
  logic                 last;

  multi_tap_remote_key_translator_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .cmd       (cmd),
    .button    (button),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .action    (action),
    .key_code  (key_code),
    .move_dx   (move_dx),
    .move_dy   (move_dy),
    .last      (last)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Give up after a generous fixed time
  initial begin
    #20_000_000;
    $display("== FAIL ==");
    $finish;
  end

  remote_evt_t pending_events[$];
  res_t        expected_actions[$];
  int          mismatch_count = 0;

  // Translator state mirrored by the predictor
  logic [TIMEOUT_W-1:0] timeout_ticks;
  logic [STEP_W-1:0]    step_x;
  logic [STEP_W-1:0]    step_y;
  logic [3:0]           prev_digit;
  logic [2:0]           tap_count;
  logic [TICK_BITS-1:0] idle_ticks;
  logic                 mouse_mode;

  // Traffic shaping knobs set between phases
  int   in_gap_style = 2;
  int   out_gap_style = 2;
  int   tap_pause_max = 40;
  logic out_hold = 1'b0;

  logic in_beat_taken = 1'b0;
  logic out_beat_taken = 1'b0;
  int   send_gap = 0;
  int   recv_gap = 0;

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= MAX_PRINTED) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic int draw_gap(input int style);
    case (style)
      0: draw_gap = 0;
      1: draw_gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 15) : 0;
      default: draw_gap = $urandom_range(0, 15);
    endcase
  endfunction

  task automatic clear_translator();
    timeout_ticks = TIMEOUT_RST;
    step_x = STEP_RST;
    step_y = STEP_RST;
    prev_digit = NO_DIGIT;
    tap_count = '0;
    idle_ticks = '0;
    mouse_mode = 1'b0;
  endtask

  // Work out the actions one accepted event causes and queue them
  task automatic translate_event(input remote_evt_t ev);
    res_t       first_beat;
    res_t       second_beat;
    int         n;
    logic       restart;
    logic [7:0] sym;
    first_beat = '0;
    second_beat = '0;
    n = 0;
    if (ev.cmd == CMD_TICK) begin
      if (idle_ticks != TICK_MAX) idle_ticks = idle_ticks + 1'b1;
    end else if (ev.button <= BTN_LAST_DIGIT) begin
      restart = (ev.button[3:0] != prev_digit) || (prev_digit == NO_DIGIT) ||
                (idle_ticks >= timeout_ticks);
      if (restart) tap_count = 3'd1;
      else if (tap_count < 3'd4) tap_count = tap_count + 3'd1;
      prev_digit = ev.button[3:0];
      idle_ticks = '0;
      first_beat.action = ACT_KEY;
      n = 1;
      if (tap_count == 3'd1) begin
        first_beat.key_code = TAP_SYMBOLS[prev_digit][0];
      end else begin
        // Erase the previous symbol, then show the next one if the key has it
        sym = TAP_SYMBOLS[prev_digit][2'(tap_count - 3'd1)];
        first_beat.key_code = KC_BACKSPACE;
        if (sym != 8'd0) begin
          second_beat.action = ACT_KEY;
          second_beat.key_code = sym;
          n = 2;
        end
      end
    end else if (ev.button == BTN_ENTER) begin
      first_beat.action = ACT_KEY;
      first_beat.key_code = KC_ENTER;
      n = 1;
    end else if (ev.button == BTN_MODE) begin
      mouse_mode = ~mouse_mode;
    end else if (ev.button >= BTN_UP && ev.button <= BTN_LEFT) begin
      n = 1;
      if (mouse_mode) begin
        first_beat.action = ACT_MOVE;
        case (ev.button)
          BTN_UP:    first_beat.move_dy = 8'd0 - {1'b0, step_y};
          BTN_DOWN:  first_beat.move_dy = {1'b0, step_y};
          BTN_RIGHT: first_beat.move_dx = {1'b0, step_x};
          default:   first_beat.move_dx = 8'd0 - {1'b0, step_x};
        endcase
      end else begin
        first_beat.action = ACT_KEY;
        case (ev.button)
          BTN_UP:    first_beat.key_code = KC_UP;
          BTN_DOWN:  first_beat.key_code = KC_DOWN;
          BTN_RIGHT: first_beat.key_code = KC_RIGHT;
          default:   first_beat.key_code = KC_LEFT;
        endcase
      end
    end else if (ev.button == BTN_CLICK && mouse_mode) begin
      first_beat.action = ACT_CLICK;
      n = 1;
    end
    if (n == 1) begin
      first_beat.last = 1'b1;
      expected_actions.push_back(first_beat);
    end else if (n == 2) begin
      second_beat.last = 1'b1;
      expected_actions.push_back(first_beat);
      expected_actions.push_back(second_beat);
    end
  endtask

  task automatic check_beat();
    res_t want;
    if (expected_actions.size() == 0) begin
      report_mismatch($sformatf("beat with nothing expected: action %0d key %0d",
                                action, key_code));
    end else begin
      want = expected_actions.pop_front();
      if (action !== want.action)
        report_mismatch($sformatf("action %0d, want %0d", action, want.action));
      if (key_code !== want.key_code)
        report_mismatch($sformatf("key_code %0d, want %0d", key_code, want.key_code));
      if (move_dx !== want.move_dx)
        report_mismatch($sformatf("move_dx %0d, want %0d", move_dx, want.move_dx));
      if (move_dy !== want.move_dy)
        report_mismatch($sformatf("move_dy %0d, want %0d", move_dy, want.move_dy));
      if (last !== want.last)
        report_mismatch($sformatf("last %0b, want %0b", last, want.last));
    end
  endtask

  // Monitor: predict on each input beat, check each output beat
  always @(posedge clk) begin
    in_beat_taken <= !rst && in_valid && in_ready;
    out_beat_taken <= !rst && out_valid && out_ready;
    if (rst) begin
      clear_translator();
    end else begin
      if (in_valid && in_ready) translate_event('{cmd: cmd, button: button});
      if (out_valid && out_ready) check_beat();
    end
  end

  // Driver: hold each beat until taken, then wait the drawn gap
  always @(negedge clk) begin
    remote_evt_t nxt;
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_beat_taken) begin
      if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (pending_events.size() > 0) begin
        nxt = pending_events.pop_front();
        cmd <= nxt.cmd;
        button <= nxt.button;
        in_valid <= 1'b1;
        send_gap = draw_gap(in_gap_style);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall for the drawn gap after each beat, or while held off
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_beat_taken) recv_gap = draw_gap(out_gap_style);
      if (out_hold) begin
        out_ready <= 1'b0;
      end else if (recv_gap > 0) begin
        out_ready <= 1'b0;
        recv_gap--;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  task automatic push_evt(input logic c, input logic [4:0] b);
    remote_evt_t e;
    e.cmd = c;
    e.button = b;
    pending_events.push_back(e);
  endtask

  task automatic push_button(input logic [4:0] b);
    push_evt(CMD_BUTTON, b);
  endtask

  // Ticks carry a random button field, which must not matter
  task automatic push_ticks(input int n);
    repeat (n) push_evt(CMD_TICK, 5'($urandom_range(0, 31)));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    case (idx)
      REG_TIMEOUT: timeout_ticks = value[TIMEOUT_W-1:0];
      REG_STEP_X:  step_x = value[STEP_W-1:0];
      REG_STEP_Y:  step_y = value[STEP_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic set_config(input int tmo, input int sx, input int sy);
    write_reg(REG_TIMEOUT, CFG_W'(tmo));
    write_reg(REG_STEP_X, CFG_W'(sx));
    write_reg(REG_STEP_Y, CFG_W'(sy));
    tap_pause_max = (tmo > 38) ? 40 : tmo + 2;
    @(posedge clk);
  endtask

  // Wait until nothing is pending or expected, then let the pipeline settle
  task automatic wait_idle();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || expected_actions.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // One multi-tap word: repeated taps of a digit, with pauses around the timeout
  task automatic queue_tap_word();
    int digit;
    int taps;
    digit = $urandom_range(0, 9);
    taps = $urandom_range(1, 6);
    repeat (taps) begin
      push_button(5'(digit));
      if ($urandom_range(0, 3) == 0) push_ticks($urandom_range(0, tap_pause_max));
      else push_ticks($urandom_range(0, 1));
    end
  endtask

  task automatic queue_random_traffic(input int n_items);
    int pick;
    int stop_at;
    stop_at = pending_events.size() + n_items;
    while (pending_events.size() < stop_at) begin
      pick = $urandom_range(0, 15);
      if (pick < 9) queue_tap_word();
      else if (pick == 9) push_button(BTN_ENTER);
      else if (pick < 12) push_button(5'($urandom_range(BTN_UP, BTN_CLICK)));
      else if (pick == 12) push_button(BTN_MODE);
      else if (pick == 13) push_ticks($urandom_range(1, tap_pause_max));
      else if (pick == 14) push_button(5'($urandom_range(BTN_OTHER, 31)));
      else push_evt(1'($urandom_range(0, 1)), 5'($urandom_range(0, 31)));
    end
  endtask

  initial begin
    int p;
    repeat (12) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);

    // Reset config: saturating taps, digit zero, digit change, arrows and click in both modes
    repeat (5) push_button(5'd2);
    repeat (4) push_button(5'd0);
    push_button(5'd7);
    push_button(5'd8);
    push_button(BTN_ENTER);
    push_button(BTN_UP);
    push_button(BTN_DOWN);
    push_button(BTN_RIGHT);
    push_button(BTN_LEFT);
    push_button(BTN_CLICK);
    push_button(5'd31);
    push_button(BTN_MODE);
    push_button(BTN_UP);
    push_button(BTN_DOWN);
    push_button(BTN_RIGHT);
    push_button(BTN_LEFT);
    push_button(BTN_CLICK);
    push_button(BTN_MODE);
    wait_idle();

    // Timeout of one tick and extreme step sizes
    set_config(1, 127, 0);
    push_button(5'd3);
    push_ticks(1);
    push_button(5'd3);
    push_button(5'd3);
    push_button(BTN_MODE);
    push_button(BTN_LEFT);
    push_button(BTN_UP);
    push_button(BTN_MODE);
    wait_idle();

    // Zero timeout restarts every tap
    set_config(0, 127, 0);
    repeat (3) push_button(5'd6);
    wait_idle();

    // Random phases over a spread of settings and idling styles
    for (p = 0; p < 8; p++) begin
      case (p)
        0: begin
          set_config(3, $urandom_range(0, 127), $urandom_range(0, 127));
          in_gap_style = 0;
          out_gap_style = 0;
        end
        1: begin
          set_config(1048575, 127, 127);
          in_gap_style = 2;
          out_gap_style = 1;
        end
        2: begin
          set_config(0, 0, 0);
          in_gap_style = 1;
          out_gap_style = 2;
        end
        3: begin
          set_config(1000, $urandom_range(0, 127), $urandom_range(0, 127));
          in_gap_style = 2;
          out_gap_style = 2;
        end
        4: begin
          set_config($urandom_range(1, 12), $urandom_range(0, 127), $urandom_range(0, 127));
          in_gap_style = 1;
          out_gap_style = 0;
        end
        default: begin
          set_config($urandom_range(1, 40), $urandom_range(0, 127), $urandom_range(0, 127));
          in_gap_style = $urandom_range(0, 2);
          out_gap_style = $urandom_range(0, 2);
        end
      endcase
      queue_random_traffic(250);
      wait_idle();
    end

    // Back-pressure: hold the output off while the sender keeps offering beats
    set_config(5, $urandom_range(0, 127), $urandom_range(0, 127));
    in_gap_style = 0;
    out_gap_style = 0;
    queue_random_traffic(80);
    out_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    out_hold <= 1'b0;
    wait_idle();

    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end

endmodule

>>> files.f
+incdir+hdl
hdl/mtkt_pkg.sv
hdl/mtkt_core.sv
hdl/mtkt_result_fifo.sv
hdl/multi_tap_remote_key_translator_unit.sv
hdl/mtkt_checker.sv
test/tb.sv
